FILE: src/eis_pkg.sv
// ---------------------------------------------------------------------------
// eis_pkg
// Shared constants and types for the epipolar inlier scorer.
// ---------------------------------------------------------------------------
package eis_pkg;

  localparam int COEF_WIDTH_DEF  = 21;
  localparam int MAX_MATCHES_DEF = 4096;

  localparam int PT_W      = 16;   // Q12.4 point coordinate
  localparam int ROW_W     = 63;   // packed matrix row
  localparam int THR_W     = 12;   // Q4.8 threshold and offset
  localparam int IDX_W     = 12;   // match index on the result
  localparam int SCORE_W   = 24;   // Q16.8 running score
  localparam int DIST_W    = 16;   // Q8.8 squared distance
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = DIST_W;        // one quotient bit per stage
  localparam int DIST_LAT  = 5 + DIV_STEPS; // register stages in eis_dist

  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(983);   // 3.84
  localparam logic [THR_W-1:0]   OFS_RST   = THR_W'(1533);  // 5.99
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FROW0,
    CFG_FROW1,
    CFG_FROW2,
    CFG_THRESH,
    CFG_OFFSET
  } cfg_reg_t;

endpackage

FILE: src/eis_dist.sv
// ---------------------------------------------------------------------------
// eis_dist
// Pipelined squared point-to-line distance, Q8.8, saturated.
// ---------------------------------------------------------------------------
module eis_dist
  import eis_pkg::*;
#(
  parameter int LW = COEF_WIDTH_DEF + 19
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [LW-1:0] l0,
  input  logic signed [LW-1:0] l1,
  input  logic signed [LW-1:0] l2,
  input  logic [PT_W-1:0]      px,
  input  logic [PT_W-1:0]      py,
  output logic [DIST_W-1:0]    distance
);

  localparam int PW  = LW + PT_W + 1;  // line coefficient times point
  localparam int NW  = LW + PT_W + 3;  // numerator
  localparam int RW  = 2 * NW;         // numerator squared
  localparam int HL  = (LW + 1) / 2;   // split of line magnitude
  localparam int HN  = (NW + 1) / 2;   // split of numerator magnitude
  localparam int QW  = 2 * LW;         // one coefficient squared

  // stage 1: products and magnitudes
  logic signed [PW-1:0] a_p0, a_p1;
  logic signed [LW-1:0] a_l2;
  logic [LW-1:0]        a_m0, a_m1;

  always_ff @(posedge clk) begin
    if (en) begin
      a_p0 <= l0 * $signed({1'b0, px});
      a_p1 <= l1 * $signed({1'b0, py});
      a_l2 <= l2;
      a_m0 <= LW'(l0[LW-1] ? -l0 : l0);
      a_m1 <= LW'(l1[LW-1] ? -l1 : l1);
    end
  end

  // stage 2: numerator sum, partial squares of the line normal
  logic signed [NW-1:0]      b_n;
  logic [2*(LW-HL)-1:0]      b_hh0, b_hh1;
  logic [LW-1:0]             b_hl0, b_hl1;
  logic [2*HL-1:0]           b_ll0, b_ll1;

  always_ff @(posedge clk) begin
    if (en) begin
      b_n   <= NW'(a_p0) + NW'(a_p1) + (NW'(a_l2) <<< 4);
      b_hh0 <= a_m0[LW-1:HL] * a_m0[LW-1:HL];
      b_hl0 <= a_m0[LW-1:HL] * a_m0[HL-1:0];
      b_ll0 <= a_m0[HL-1:0]  * a_m0[HL-1:0];
      b_hh1 <= a_m1[LW-1:HL] * a_m1[LW-1:HL];
      b_hl1 <= a_m1[LW-1:HL] * a_m1[HL-1:0];
      b_ll1 <= a_m1[HL-1:0]  * a_m1[HL-1:0];
    end
  end

  // stage 3: numerator magnitude, each square assembled
  logic [NW-1:0] c_nm;
  logic [QW-1:0] c_q0, c_q1;

  always_ff @(posedge clk) begin
    if (en) begin
      c_nm <= NW'(b_n[NW-1] ? -b_n : b_n);
      c_q0 <= (QW'(b_hh0) << (2 * HL)) + (QW'(b_hl0) << (HL + 1)) + QW'(b_ll0);
      c_q1 <= (QW'(b_hh1) << (2 * HL)) + (QW'(b_hl1) << (HL + 1)) + QW'(b_ll1);
    end
  end

  // stage 4: partial squares of the numerator, norm sum
  logic [2*(NW-HN)-1:0] d_hh;
  logic [NW-1:0]        d_hl;
  logic [2*HN-1:0]      d_ll;
  logic [QW:0]          d_d;

  always_ff @(posedge clk) begin
    if (en) begin
      d_hh <= c_nm[NW-1:HN] * c_nm[NW-1:HN];
      d_hl <= c_nm[NW-1:HN] * c_nm[HN-1:0];
      d_ll <= c_nm[HN-1:0]  * c_nm[HN-1:0];
      d_d  <= (QW+1)'(c_q0) + (QW+1)'(c_q1);
    end
  end

  // stage 5: numerator squared, zero norm flag
  logic [RW-1:0] e_nsq;
  logic [QW:0]   e_d;
  logic          e_dz;

  always_ff @(posedge clk) begin
    if (en) begin
      e_nsq <= (RW'(d_hh) << (2 * HN)) + (RW'(d_hl) << (HN + 1)) + RW'(d_ll);
      e_d   <= d_d;
      e_dz  <= (d_d == '0);
    end
  end

  // restoring division, one quotient bit per stage, msb first
  logic [RW-1:0]     r_rem [DIV_STEPS];
  logic [DIST_W-1:0] r_q   [DIV_STEPS];
  logic [QW:0]       r_d   [DIV_STEPS];
  logic              r_dz  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [RW-1:0]     rem_in;
    logic [DIST_W-1:0] q_in;
    logic [QW:0]       d_in;
    logic              dz_in;
    logic [RW-1:0]     trial;

    if (j == 0) begin : g_first
      assign rem_in = e_nsq;
      assign q_in   = '0;
      assign d_in   = e_d;
      assign dz_in  = e_dz;
    end else begin : g_next
      assign rem_in = r_rem[j-1];
      assign q_in   = r_q[j-1];
      assign d_in   = r_d[j-1];
      assign dz_in  = r_dz[j-1];
    end

    assign trial = RW'(d_in) << (DIV_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (en) begin
        r_d[j]  <= d_in;
        r_dz[j] <= dz_in;
        if (trial <= rem_in) begin
          r_rem[j] <= rem_in - trial;
          r_q[j]   <= q_in | (DIST_W'(1) << (DIV_STEPS - 1 - j));
        end else begin
          r_rem[j] <= rem_in;
          r_q[j]   <= q_in;
        end
      end
    end
  end

  // zero norm reads as the largest distance
  assign distance = r_dz[DIV_STEPS-1] ? DIST_MAX : r_q[DIV_STEPS-1];

endmodule

FILE: src/epipolar_inlier_scorer.sv
// ---------------------------------------------------------------------------
// epipolar_inlier_scorer
// Symmetric epipolar distance inlier test with a running saturated score.
// ---------------------------------------------------------------------------
// channel  direction  handshake            payload
// input    in         in_valid/in_stall    p1_x p1_y p2_x p2_y final_match
// result   out        out_valid/out_stall  match_index inlier score final_result
// config   in         cfg_we               cfg_index cfg_data
//
// One word per cycle is taken unless held. Words pass t1, t2, eis_dist (each
// with a 16-stage restoring divider), the score stage and an output register.
// The whole pipeline holds while out_valid is high and out_stall is set;
// in_stall mirrors that hold. Synchronous reset clears valid bits, the pair
// counter, the score and the registers to their reset values.
// ---------------------------------------------------------------------------
module epipolar_inlier_scorer
  import eis_pkg::*;
#(
  parameter int MAX_MATCHES = MAX_MATCHES_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PT_W-1:0]      p1_x,
  input  logic [PT_W-1:0]      p1_y,
  input  logic [PT_W-1:0]      p2_x,
  input  logic [PT_W-1:0]      p2_y,
  input  logic                 final_match,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     match_index,
  output logic                 inlier,
  output logic [SCORE_W-1:0]   score,
  output logic                 final_result
);

  localparam int CW    = COEF_WIDTH;
  localparam int PW    = CW + PT_W + 1;
  localparam int LW    = CW + PT_W + 3;
  localparam int CNT_W = $clog2(MAX_MATCHES);
  localparam int NST   = DIST_LAT + 3;  // t1, t2, divider path, score stage
  localparam int ADD_W = THR_W + 2;

  // configuration registers
  logic [ROW_W-1:0] fmat [3];
  logic [THR_W-1:0] thresh;
  logic [THR_W-1:0] offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmat[0] <= '0;
      fmat[1] <= '0;
      fmat[2] <= '0;
      thresh  <= THR_RST;
      offset  <= OFS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FROW0:  fmat[0] <= cfg_data;
        CFG_FROW1:  fmat[1] <= cfg_data;
        CFG_FROW2:  fmat[2] <= cfg_data;
        CFG_THRESH: thresh  <= cfg_data[THR_W-1:0];
        CFG_OFFSET: offset  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // unpacked coefficients
  logic signed [CW-1:0] fc [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        fc[r][c] = fmat[r][c*CW +: CW];
      end
    end
  end

  // global advance: hold everything while a result waits
  logic en;
  logic [NST-1:0] vld;
  logic [NST-1:0] fin_p;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_p <= {fin_p[NST-2:0], final_match};
    end
  end

  // t1: coefficient by coordinate products for both lines
  logic signed [PW-1:0] pl0 [3], pl1 [3], pm0 [3], pm1 [3];
  logic signed [CW-1:0] pl2 [3], pm2 [3];
  logic [PT_W-1:0]      a_x1, a_y1, a_x2, a_y2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl0[i] <= fc[i][0] * $signed({1'b0, p1_x});
        pl1[i] <= fc[i][1] * $signed({1'b0, p1_y});
        pl2[i] <= fc[i][2];
        pm0[i] <= fc[0][i] * $signed({1'b0, p2_x});
        pm1[i] <= fc[1][i] * $signed({1'b0, p2_y});
        pm2[i] <= fc[2][i];
      end
      a_x1 <= p1_x;
      a_y1 <= p1_y;
      a_x2 <= p2_x;
      a_y2 <= p2_y;
    end
  end

  // t2: line coefficients, F*p1 and F^T*p2
  logic signed [LW-1:0] ln [3], lm [3];
  logic [PT_W-1:0]      b_x1, b_y1, b_x2, b_y2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ln[i] <= LW'(pl0[i]) + LW'(pl1[i]) + (LW'(pl2[i]) <<< 4);
        lm[i] <= LW'(pm0[i]) + LW'(pm1[i]) + (LW'(pm2[i]) <<< 4);
      end
      b_x1 <= a_x1;
      b_y1 <= a_y1;
      b_x2 <= a_x2;
      b_y2 <= a_y2;
    end
  end

  // distances in both directions
  logic [DIST_W-1:0] dist1, dist2;

  eis_dist #(.LW(LW)) u_dist_fwd (
    .clk      (clk),
    .en       (en),
    .l0       (ln[0]),
    .l1       (ln[1]),
    .l2       (ln[2]),
    .px       (b_x2),
    .py       (b_y2),
    .distance (dist1)
  );

  eis_dist #(.LW(LW)) u_dist_bwd (
    .clk      (clk),
    .en       (en),
    .l0       (lm[0]),
    .l1       (lm[1]),
    .l2       (lm[2]),
    .px       (b_x1),
    .py       (b_y1),
    .distance (dist2)
  );

  // score stage: threshold test and contribution
  logic              ok1, ok2;
  logic [THR_W:0]    add1, add2;
  logic [ADD_W-1:0]  sc_add;
  logic              sc_inl;

  always_comb begin
    ok1  = dist1 <= DIST_W'(thresh);
    ok2  = dist2 <= DIST_W'(thresh);
    add1 = (ok1 && DIST_W'(offset) > dist1) ? (THR_W+1)'(offset - dist1[THR_W-1:0]) : '0;
    add2 = (ok2 && DIST_W'(offset) > dist2) ? (THR_W+1)'(offset - dist2[THR_W-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_add <= ADD_W'(add1) + ADD_W'(add2);
      sc_inl <= ok1 && ok2;
    end
  end

  // running totals and result word
  logic [CNT_W-1:0]   cnt;
  logic [SCORE_W-1:0] score_acc;
  logic [SCORE_W:0]   tot;
  logic [SCORE_W-1:0] score_next;

  assign tot        = (SCORE_W+1)'(score_acc) + (SCORE_W+1)'(sc_add);
  assign score_next = tot[SCORE_W] ? SCORE_MAX : tot[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
      score_acc <= '0;
    end else if (en) begin
      out_valid <= vld[NST-1];
      if (vld[NST-1]) begin
        if (fin_p[NST-1]) begin
          cnt       <= '0;
          score_acc <= '0;
        end else begin
          cnt       <= (cnt == CNT_W'(MAX_MATCHES - 1)) ? '0 : cnt + 1'b1;
          score_acc <= score_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[NST-1]) begin
      match_index  <= IDX_W'(cnt);
      inlier       <= sc_inl;
      score        <= score_next;
      final_result <= fin_p[NST-1];
    end
  end

endmodule

FILE: bench/eis_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eis_checker
// Watches the config port and both channels of the epipolar inlier scorer,
// predicts each result word from the accepted input word and compares them.
// ---------------------------------------------------------------------------
module eis_checker
  import eis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PT_W-1:0]      p1_x,
  input  logic [PT_W-1:0]      p1_y,
  input  logic [PT_W-1:0]      p2_x,
  input  logic [PT_W-1:0]      p2_y,
  input  logic                 final_match,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [IDX_W-1:0]     match_index,
  input  logic                 inlier,
  input  logic [SCORE_W-1:0]   score,
  input  logic                 final_result,
  output int                   errors,
  output int                   pending,
  output int                   results,
  output int                   inliers
);

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               inl;
    logic [SCORE_W-1:0] scr;
    logic               fin;
  } score_word_t;

  score_word_t        expected_words[$];
  logic [ROW_W-1:0]   frow[3];
  logic [THR_W-1:0]   thresh;
  logic [THR_W-1:0]   offset;
  logic [IDX_W-1:0]   pair_cnt;
  logic [SCORE_W-1:0] run_score;

  assign pending = expected_words.size();

  // signed Q2.18 coefficient F[r][c]
  function automatic longint fcoef(int r, int c);
    logic signed [COEF_WIDTH_DEF-1:0] f;
    f = frow[r][c*COEF_WIDTH_DEF +: COEF_WIDTH_DEF];
    return longint'(f);
  endfunction

  // squared point-to-line distance, Q8.8, saturated; zero norm gives maximum
  function automatic logic [DIST_W-1:0] sq_dist(longint l0, longint l1, longint l2,
                                                longint x, longint y);
    longint       n;
    logic [127:0] a0, a1, an, den, nsq, q;
    n   = l0 * x + l1 * y + l2 * 16;
    a0  = {64'd0, (l0 < 0) ? -l0 : l0};
    a1  = {64'd0, (l1 < 0) ? -l1 : l1};
    an  = {64'd0, (n < 0) ? -n : n};
    den = a0 * a0 + a1 * a1;
    nsq = an * an;
    if (den == 0) return DIST_MAX;
    q = nsq / den;
    return (q > 128'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
  endfunction

  always @(posedge clk) begin
    score_word_t w;
    longint      l[3], m[3];
    logic [DIST_W-1:0] d1, d2;
    logic        ok1, ok2;
    logic [SCORE_W+1:0] sum;
    if (rst) begin
      frow[0] = '0; frow[1] = '0; frow[2] = '0;
      thresh = THR_RST;
      offset = OFS_RST;
      pair_cnt = '0;
      run_score = '0;
      expected_words.delete();
      errors = 0; results = 0; inliers = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_FROW0:  frow[0] = cfg_data;
          CFG_FROW1:  frow[1] = cfg_data;
          CFG_FROW2:  frow[2] = cfg_data;
          CFG_THRESH: thresh = cfg_data[THR_W-1:0];
          CFG_OFFSET: offset = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      // compare result word with the oldest prediction
      if (out_valid && !out_stall) begin
        results++;
        if (inlier) inliers++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word idx=%0d inlier=%0d score=%0d fin=%0d",
                   $time, match_index, inlier, score, final_result);
        end else begin
          w = expected_words.pop_front();
          if (match_index !== w.idx) begin
            errors++;
            $display("%0t: match_index expected %0d actual %0d", $time, w.idx, match_index);
          end
          if (inlier !== w.inl) begin
            errors++;
            $display("%0t: inlier expected %0d actual %0d", $time, w.inl, inlier);
          end
          if (score !== w.scr) begin
            errors++;
            $display("%0t: score expected %0d actual %0d", $time, w.scr, score);
          end
          if (final_result !== w.fin) begin
            errors++;
            $display("%0t: final_result expected %0d actual %0d", $time, w.fin,
                     final_result);
          end
        end
      end
      // predict from the accepted input word
      if (in_valid && !in_stall) begin
        for (int i = 0; i < 3; i++) begin
          l[i] = fcoef(i, 0) * longint'(p1_x) + fcoef(i, 1) * longint'(p1_y)
               + fcoef(i, 2) * 16;
          m[i] = fcoef(0, i) * longint'(p2_x) + fcoef(1, i) * longint'(p2_y)
               + fcoef(2, i) * 16;
        end
        d1 = sq_dist(l[0], l[1], l[2], longint'(p2_x), longint'(p2_y));
        d2 = sq_dist(m[0], m[1], m[2], longint'(p1_x), longint'(p1_y));
        ok1 = d1 <= thresh;
        ok2 = d2 <= thresh;
        sum = (SCORE_W+2)'(run_score);
        if (ok1 && offset > d1) sum += (SCORE_W+2)'(offset - d1);
        if (ok2 && offset > d2) sum += (SCORE_W+2)'(offset - d2);
        run_score = (sum > SCORE_MAX) ? SCORE_MAX : sum[SCORE_W-1:0];
        w.idx = pair_cnt;
        w.inl = ok1 && ok2;
        w.scr = run_score;
        w.fin = final_match;
        expected_words.push_back(w);
        if (final_match) begin
          pair_cnt = '0;
          run_score = '0;
        end else begin
          pair_cnt = pair_cnt + 1'b1;
        end
      end
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus for the epipolar inlier scorer: directed corner pairs, then
// phases of random matrices, thresholds and near-epipolar point pairs under
// varied idling and a long receiver hold; the checker does the comparing.
// ---------------------------------------------------------------------------
module testbench;
  import eis_pkg::*;

  logic                 clk, rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;
  logic                 in_valid, in_stall;
  logic [PT_W-1:0]      p1_x, p1_y, p2_x, p2_y;
  logic                 final_match;
  logic                 out_valid, out_stall;
  logic [IDX_W-1:0]     match_index;
  logic                 inlier;
  logic [SCORE_W-1:0]   score;
  logic                 final_result;
  int                   errors, pending, results, inliers;

  int   send_idle_pct, recv_stall_pct;
  logic hold_req;
  int   sent;

  epipolar_inlier_scorer uut (.*);

  eis_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, with one long counted hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one word; called at a falling edge, returns at a falling edge
  task automatic send_pair(logic [15:0] x1, y1, x2, y2, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    p1_x <= x1; p1_y <= y1; p2_x <= x2; p2_y <= y2; final_match <= fin;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  // registers change only once the pipeline has drained
  task automatic write_reg(cfg_reg_t r, logic [ROW_W-1:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DIST_LAT + 10) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= r; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // pure translation matrix: epipolar lines are horizontal, distance = dy^2
  task automatic set_translation(logic [20:0] a);
    write_reg(CFG_FROW0, '0);
    write_reg(CFG_FROW1, {-a, 21'd0, 21'd0});
    write_reg(CFG_FROW2, {21'd0, a, 21'd0});
  endtask

  function automatic logic [62:0] rand_row();
    return 63'({$urandom(), $urandom()});
  endfunction

  // near-epipolar pair under translation, or pure noise
  task automatic send_random(int fin_pct);
    logic [15:0] y1;
    y1 = 16'($urandom());
    if ($urandom_range(99) < 80)
      send_pair(16'($urandom()), y1, 16'($urandom()),
                y1 + 16'($signed($urandom_range(80)) - 40),
                $urandom_range(99) < fin_pct);
    else
      send_pair(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                $urandom_range(99) < fin_pct);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; final_match = 1'b0;
    p1_x = '0; p1_y = '0; p2_x = '0; p2_y = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b0; sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero matrix after reset: zero line norm, both directions fail
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // translation at the largest positive coefficient, extreme points
    set_translation(21'h0FFFFF);
    send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_pair(16'h1234, 16'h0100, 16'h4321, 16'h011F, 1'b0);
    send_pair(16'h1234, 16'h0100, 16'h4321, 16'h0120, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
    // most negative coefficient; offset below distance
    set_translation(21'h100000);
    write_reg(CFG_THRESH, ROW_W'(12'hFFF));
    write_reg(CFG_OFFSET, ROW_W'(12'd0));
    send_pair(16'h0010, 16'h0200, 16'h0020, 16'h0210, 1'b0);
    send_pair(16'h0010, 16'h0200, 16'h0020, 16'h0240, 1'b1);
    write_reg(CFG_THRESH, ROW_W'(12'd0));
    write_reg(CFG_OFFSET, ROW_W'(12'hFFF));
    send_pair(16'h0010, 16'h0200, 16'h0020, 16'h0200, 1'b0);
    send_pair(16'h0010, 16'h0200, 16'h0020, 16'h0201, 1'b1);
    // all-ones matrix rows
    write_reg(CFG_FROW0, '1);
    write_reg(CFG_FROW1, '1);
    write_reg(CFG_FROW2, '1);
    send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);

    // random phases over settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph == 5) begin
        write_reg(CFG_FROW0, rand_row());
        write_reg(CFG_FROW1, rand_row());
        write_reg(CFG_FROW2, rand_row());
      end else begin
        set_translation(21'($urandom_range(1, 21'h0FFFFF)) ^ (ph[0] ? 21'h1FFFFF : 21'h0));
      end
      write_reg(CFG_THRESH, ROW_W'((ph == 7) ? 12'hFFF : 12'($urandom())));
      write_reg(CFG_OFFSET, ROW_W'((ph == 6) ? 12'd0 : 12'($urandom())));
      if (ph == 0) hold_req = 1'b1;
      for (int i = 0; i < 112; i++) send_random(5);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DIST_LAT + 20) @(negedge clk);
    $display("Pairs sent %0d, result words %0d, inliers %0d, errors %0d",
             sent, results, inliers, errors);
    $display("Covered zero norm, coefficient extremes, offset below distance, stalls");
    $display("and a long output hold that filled the pipeline");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
